[rtl/core/ecfs_pkg.sv]
// Package for the exposure coarse/fine sweep controller.
// Holds field widths, search constants, result kind codes and the transaction structs.
// No dependencies.
`default_nettype none

package ecfs_pkg;

  localparam int EXPOSURE_BITS      = 16;
  localparam int GRADE_BITS         = 16;
  localparam int CFG_BITS           = 16;
  localparam int MAX_EXPOSURE_RESET = 10000;

  localparam int COARSE_STEPS = 10;
  localparam int WINDOW_STEPS = 3;
  localparam int FINE_DIV     = 50;
  localparam int HALF_DIV     = 2;

  localparam int QUEUE_DEPTH = 3;

  typedef enum logic [1:0] {
    KIND_MEASURE     = 2'd0,
    KIND_COARSE_BEST = 2'd1,
    KIND_FINAL       = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  action;
    logic [GRADE_BITS-1:0] grade;
  } item_t;

  typedef struct packed {
    logic [EXPOSURE_BITS-1:0] exposure;
    kind_t                    kind;
    logic [GRADE_BITS-1:0]    best_grade;
    logic                     last;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/exposure_coarse_fine_sweep.sv]
// Top level of the exposure coarse/fine sweep controller.
// Depends on ecfs_pkg for widths, constants and the item/result structs.
`default_nettype none

// A start item (action 0) opens a search and requests exposure 0; each grade
// report (action 1) during a search answers the last request and yields the
// next request, the coarse-best exposure, or the final best. One item is
// accepted per clock while item_stall is low; its results are queued in a
// three-entry output queue and, with the queue empty, the first appears on
// result the cycle after acceptance. item_stall rises while the queue holds
// two or more results. The queue always holds two or more in the cycle after
// an item that yields two results, so item_stall holds off the next item; items
// that yield one result each follow back to back while the result side keeps
// draining. Coarse and fine step are derived from max_exposure by reciprocal
// multiplies in the cycles after a start; grades are never needed that early.
module exposure_coarse_fine_sweep (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          max_exposure_we,
  input  logic [ecfs_pkg::CFG_BITS-1:0] max_exposure_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ecfs_pkg::item_t               item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ecfs_pkg::result_t             result
);
  import ecfs_pkg::*;

  localparam int EB = EXPOSURE_BITS;
  localparam int GB = GRADE_BITS;

  localparam int D10_SHIFT = EB + 4;
  localparam int D10_W     = 2 * EB + 5;
  localparam logic [EB:0] D10_MUL =
    (EB+1)'(((64'd1 << D10_SHIFT) + 64'(COARSE_STEPS) - 64'd1) / 64'(COARSE_STEPS));

  localparam int D50_SHIFT = EB + 6;
  localparam int D50_W     = 2 * EB + 7;
  localparam logic [EB:0] D50_MUL =
    (EB+1)'(((64'd1 << D50_SHIFT) + 64'(FINE_DIV) - 64'd1) / 64'(FINE_DIV));

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_COARSE,
    PH_FINE
  } phase_t;

  logic [EB-1:0] max_exposure;
  phase_t        phase, phase_next;
  logic [3:0]    coarse_count, coarse_count_next;
  logic [EB:0]   current_exposure, current_exposure_next;
  logic [EB-1:0] best_exposure, best_exposure_next;
  logic [GB-1:0] best_grade_kept, best_grade_kept_next;
  logic [EB-1:0] coarse_step, coarse_step_next;
  logic [EB-1:0] fine_end, fine_end_next;
  logic [EB-1:0] window_range, window_range_next;
  logic [EB-1:0] fine_step, fine_step_next;

  logic [D10_W-1:0] d10_prod;
  logic [D50_W-1:0] d50_prod;
  logic [EB-1:0]    d50_quot;
  logic [EB-1:0]    half;

  result_t    q [QUEUE_DEPTH];
  result_t    q_next [QUEUE_DEPTH];
  logic [1:0] q_count, q_count_next;
  logic [1:0] q_base;
  logic       pop;
  logic       accept;

  logic [1:0]    n_res;
  result_t       r0, r1;
  logic          grade_better;
  logic [GB-1:0] bg_take;
  logic [EB-1:0] be_take;
  logic [EB:0]   hi_sum;
  logic [EB-1:0] win_start, win_end;
  logic [EB:0]   fine_next;

  function automatic result_t make_result(logic [EB-1:0] exp, kind_t kind,
                                          logic [GB-1:0] bg, logic last);
    result_t r;
    r.exposure   = exp;
    r.kind       = kind;
    r.best_grade = bg;
    r.last       = last;
    return r;
  endfunction

  assign d10_prod         = D10_W'(max_exposure) * D10_W'(D10_MUL);
  assign coarse_step_next = d10_prod[D10_SHIFT +: EB];

  assign window_range_next = EB'((EB+2)'(coarse_step) * (EB+2)'(WINDOW_STEPS));
  assign half              = EB'(window_range / HALF_DIV);

  assign d50_prod       = D50_W'(window_range) * D50_W'(D50_MUL);
  assign d50_quot       = d50_prod[D50_SHIFT +: EB];
  assign fine_step_next = (d50_quot == '0) ? EB'(1) : d50_quot;

  assign item_stall   = (q_count >= 2'd2);
  assign accept       = item_valid && !item_stall;
  assign result_valid = (q_count != 2'd0);
  assign result       = q[0];
  assign pop          = result_valid && !result_stall;

  always_comb begin
    grade_better = item.grade > best_grade_kept;
    bg_take      = grade_better ? item.grade : best_grade_kept;
    be_take      = grade_better ? EB'(current_exposure) : best_exposure;

    hi_sum = (EB+1)'(be_take) + (EB+1)'(half);
    if (hi_sum > (EB+1)'(max_exposure)) begin
      win_start = (max_exposure >= window_range) ? max_exposure - window_range : '0;
      win_end   = max_exposure;
    end else if (be_take < half) begin
      win_start = '0;
      win_end   = window_range;
    end else begin
      win_start = be_take - half;
      win_end   = be_take + half;
    end

    fine_next = current_exposure + (EB+1)'(fine_step);
  end

  always_comb begin
    phase_next            = phase;
    coarse_count_next     = coarse_count;
    current_exposure_next = current_exposure;
    best_exposure_next    = best_exposure;
    best_grade_kept_next  = best_grade_kept;
    fine_end_next         = fine_end;
    n_res                 = 2'd0;
    r0                    = '0;
    r1                    = '0;
    if (accept) begin
      if (!item.action) begin
        phase_next            = PH_FIRST;
        coarse_count_next     = '0;
        current_exposure_next = '0;
        best_exposure_next    = '0;
        best_grade_kept_next  = '0;
        fine_end_next         = '0;
        n_res                 = 2'd1;
        r0                    = make_result('0, KIND_MEASURE, '0, 1'b1);
      end else begin
        case (phase)
          PH_FIRST: begin
            best_grade_kept_next  = item.grade;
            best_exposure_next    = '0;
            coarse_count_next     = 4'd1;
            current_exposure_next = (EB+1)'(coarse_step);
            phase_next            = PH_COARSE;
            n_res                 = 2'd1;
            r0 = make_result(coarse_step, KIND_MEASURE, item.grade, 1'b1);
          end
          PH_COARSE: begin
            best_grade_kept_next = bg_take;
            best_exposure_next   = be_take;
            if (coarse_count < 4'(COARSE_STEPS)) begin
              coarse_count_next     = coarse_count + 4'd1;
              current_exposure_next = current_exposure + (EB+1)'(coarse_step);
              n_res                 = 2'd1;
              r0 = make_result(EB'(current_exposure + (EB+1)'(coarse_step)),
                               KIND_MEASURE, bg_take, 1'b1);
            end else begin
              fine_end_next = win_end;
              n_res         = 2'd2;
              r0            = make_result(be_take, KIND_COARSE_BEST, bg_take, 1'b0);
              if (win_start < win_end) begin
                current_exposure_next = (EB+1)'(win_start);
                phase_next            = PH_FINE;
                r1 = make_result(win_start, KIND_MEASURE, bg_take, 1'b1);
              end else begin
                phase_next = PH_IDLE;
                r1         = make_result(be_take, KIND_FINAL, bg_take, 1'b1);
              end
            end
          end
          PH_FINE: begin
            best_grade_kept_next = bg_take;
            best_exposure_next   = be_take;
            n_res                = 2'd1;
            if (fine_next < (EB+1)'(fine_end)) begin
              current_exposure_next = fine_next;
              r0 = make_result(EB'(fine_next), KIND_MEASURE, bg_take, 1'b1);
            end else begin
              phase_next = PH_IDLE;
              r0         = make_result(be_take, KIND_FINAL, bg_take, 1'b1);
            end
          end
          default: begin
            n_res = 2'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    q_base = q_count - {1'b0, pop};
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_next[i] = q[i];
      if (pop && i < QUEUE_DEPTH - 1) begin
        q_next[i] = q[(i + 1) % QUEUE_DEPTH];
      end
      if (n_res != 2'd0 && 2'(i) == q_base) begin
        q_next[i] = r0;
      end else if (n_res == 2'd2 && 2'(i) == q_base + 2'd1) begin
        q_next[i] = r1;
      end
    end
    q_count_next = q_base + n_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_exposure     <= EB'(MAX_EXPOSURE_RESET);
      phase            <= PH_IDLE;
      coarse_count     <= '0;
      current_exposure <= '0;
      best_exposure    <= '0;
      best_grade_kept  <= '0;
      coarse_step      <= '0;
      fine_end         <= '0;
      q_count          <= '0;
    end else begin
      if (max_exposure_we) begin
        max_exposure <= EB'(max_exposure_data);
      end
      phase            <= phase_next;
      coarse_count     <= coarse_count_next;
      current_exposure <= current_exposure_next;
      best_exposure    <= best_exposure_next;
      best_grade_kept  <= best_grade_kept_next;
      fine_end         <= fine_end_next;
      if (accept && !item.action) begin
        coarse_step <= coarse_step_next;
      end
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    window_range <= window_range_next;
    fine_step    <= fine_step_next;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for exposure_coarse_fine_sweep: directed searches, then random
// coarse/fine sweeps under several max_exposure settings and idle patterns.
// Depends on ecfs_pkg and the exposure_coarse_fine_sweep RTL.

module testbench;
  import ecfs_pkg::*;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_GRADE = 1'b1;
  localparam int RUN_LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int ITEMS_PER_PHASE = 650;
  localparam int MAX_REPORTS = 10;
  localparam logic [GRADE_BITS-1:0] GRADE_TOP = '1;
  localparam logic [EXPOSURE_BITS-1:0] NOTABLE_MAX [10] =
    '{0, 9, 10, 49, 166, 167, 1666, 1667, 10000, 65535};

  typedef enum logic [1:0] {SWEEP_IDLE, SWEEP_FIRST, SWEEP_COARSE, SWEEP_FINE} sweep_phase_t;
  typedef enum int {SHAPE_NOISE, SHAPE_FLAT, SHAPE_RISING, SHAPE_FALLING, SHAPE_PEAK} grade_shape_t;

  typedef struct {
    item_t payload;
    bit    after_drain;
  } camera_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                max_exposure_we = 1'b0;
  logic [CFG_BITS-1:0] max_exposure_data = '0;
  logic                item_valid = 1'b0;
  logic                item_stall;
  item_t               item = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  result_t             result;

  camera_item_t camera_items[$];
  result_t      sweep_outputs_due[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned items_pushed = 0;
  int unsigned items_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned bad_results = 0;
  int unsigned searches = 0;
  int unsigned searches_cut = 0;
  int unsigned settings_used = 0;
  bit          item_taken = 1'b0;
  bit          prev_was_start = 1'b0;
  logic [EXPOSURE_BITS-1:0] stim_max = EXPOSURE_BITS'(MAX_EXPOSURE_RESET);

  logic [EXPOSURE_BITS-1:0] sw_max;
  sweep_phase_t             sw_phase;
  logic [3:0]               sw_count;
  logic [EXPOSURE_BITS:0]   sw_cur;
  logic [EXPOSURE_BITS-1:0] sw_best_exp;
  logic [GRADE_BITS-1:0]    sw_best_grade;
  logic [EXPOSURE_BITS-1:0] sw_coarse_step;
  logic [EXPOSURE_BITS-1:0] sw_fine_step;
  logic [EXPOSURE_BITS:0]   sw_fine_end;

  exposure_coarse_fine_sweep DUT (
    .clk               (clk),
    .rst               (rst),
    .max_exposure_we   (max_exposure_we),
    .max_exposure_data (max_exposure_data),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .item              (item),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .result            (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_sweep();
    sw_max = EXPOSURE_BITS'(MAX_EXPOSURE_RESET);
    sw_phase = SWEEP_IDLE;
    sw_count = '0;
    sw_cur = '0;
    sw_best_exp = '0;
    sw_best_grade = '0;
    sw_coarse_step = '0;
    sw_fine_step = '0;
    sw_fine_end = '0;
  endfunction

  function automatic void emit_output(logic [EXPOSURE_BITS-1:0] exposure, kind_t kind,
                                      logic last);
    result_t r;
    r.exposure = exposure;
    r.kind = kind;
    r.best_grade = sw_best_grade;
    r.last = last;
    sweep_outputs_due.push_back(r);
  endfunction

  function automatic void keep_if_sharper(logic [GRADE_BITS-1:0] g);
    if (g > sw_best_grade) begin
      sw_best_grade = g;
      sw_best_exp = sw_cur[EXPOSURE_BITS-1:0];
    end
  endfunction

  function automatic void advance_sweep(item_t it);
    int unsigned span, half, lo, hi, nxt;
    if (it.action == ACT_START) begin
      sw_phase = SWEEP_FIRST;
      sw_count = '0;
      sw_cur = '0;
      sw_best_exp = '0;
      sw_best_grade = '0;
      sw_coarse_step = EXPOSURE_BITS'(sw_max / COARSE_STEPS);
      sw_fine_step = '0;
      sw_fine_end = '0;
      emit_output('0, KIND_MEASURE, 1'b1);
    end else begin
      case (sw_phase)
        SWEEP_FIRST: begin
          sw_best_grade = it.grade;
          sw_best_exp = '0;
          sw_count = 4'd1;
          sw_cur = (EXPOSURE_BITS+1)'(sw_coarse_step);
          sw_phase = SWEEP_COARSE;
          emit_output(sw_cur[EXPOSURE_BITS-1:0], KIND_MEASURE, 1'b1);
        end
        SWEEP_COARSE: begin
          keep_if_sharper(it.grade);
          if (sw_count < COARSE_STEPS) begin
            sw_count = sw_count + 4'd1;
            sw_cur = sw_cur + (EXPOSURE_BITS+1)'(sw_coarse_step);
            emit_output(sw_cur[EXPOSURE_BITS-1:0], KIND_MEASURE, 1'b1);
          end else begin
            span = sw_coarse_step * WINDOW_STEPS;
            half = span / HALF_DIV;
            if (sw_best_exp + half > sw_max) begin
              lo = (sw_max >= span) ? sw_max - span : 0;
              hi = sw_max;
            end else if (sw_best_exp < half) begin
              lo = 0;
              hi = span;
            end else begin
              lo = sw_best_exp - half;
              hi = sw_best_exp + half;
            end
            sw_fine_step = EXPOSURE_BITS'(span / FINE_DIV);
            if (sw_fine_step == '0) sw_fine_step = EXPOSURE_BITS'(1);
            sw_fine_end = (EXPOSURE_BITS+1)'(hi);
            emit_output(sw_best_exp, KIND_COARSE_BEST, 1'b0);
            if (lo < hi) begin
              sw_cur = (EXPOSURE_BITS+1)'(lo);
              sw_phase = SWEEP_FINE;
              emit_output(sw_cur[EXPOSURE_BITS-1:0], KIND_MEASURE, 1'b1);
            end else begin
              sw_phase = SWEEP_IDLE;
              emit_output(sw_best_exp, KIND_FINAL, 1'b1);
            end
          end
        end
        SWEEP_FINE: begin
          keep_if_sharper(it.grade);
          nxt = sw_cur + sw_fine_step;
          if (nxt < sw_fine_end) begin
            sw_cur = (EXPOSURE_BITS+1)'(nxt);
            emit_output(sw_cur[EXPOSURE_BITS-1:0], KIND_MEASURE, 1'b1);
          end else begin
            sw_phase = SWEEP_IDLE;
            emit_output(sw_best_exp, KIND_FINAL, 1'b1);
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void note_bad_result(string what, result_t want, result_t got);
    bad_results++;
    if (bad_results <= MAX_REPORTS)
      $display("%0t %s: expected exposure %0d kind %0d best_grade %0d last %0d,", $time, what,
               want.exposure, want.kind, want.best_grade, want.last,
               " got exposure %0d kind %0d best_grade %0d last %0d",
               got.exposure, got.kind, got.best_grade, got.last);
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    item_taken = 1'b0;
    if (rst) begin
      clear_sweep();
    end else begin
      if (max_exposure_we) sw_max = max_exposure_data;
      if (item_valid && !item_stall) begin
        item_taken = 1'b1;
        items_accepted++;
        advance_sweep(item);
      end
      if (result_valid && !result_stall) begin
        results_checked++;
        if (sweep_outputs_due.size() == 0) begin
          note_bad_result("result with none due", '0, result);
        end else begin
          want = sweep_outputs_due.pop_front();
          if (result.exposure !== want.exposure || result.kind !== want.kind ||
              result.best_grade !== want.best_grade || result.last !== want.last)
            note_bad_result("result mismatch", want, result);
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    camera_item_t next_item;
    if (!rst && (!item_valid || item_taken)) begin
      if (camera_items.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!camera_items[0].after_drain || sweep_outputs_due.size() == 0)) begin
        next_item = camera_items.pop_front();
        item_valid <= 1'b1;
        item <= next_item.payload;
      end else begin
        item_valid <= 1'b0;
      end
    end
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // hold any item that follows a start until the exposure 0 request is out
  function automatic void queue_item(logic action, logic [GRADE_BITS-1:0] grade);
    camera_item_t c;
    c.payload.action = action;
    c.payload.grade = grade;
    c.after_drain = prev_was_start;
    camera_items.push_back(c);
    prev_was_start = (action == ACT_START);
    items_pushed++;
  endfunction

  function automatic int unsigned fine_points(logic [EXPOSURE_BITS-1:0] mx);
    int unsigned span, stride;
    span = (mx / COARSE_STEPS) * WINDOW_STEPS;
    stride = (span / FINE_DIV == 0) ? 1 : span / FINE_DIV;
    return (span + stride - 1) / stride;
  endfunction

  function automatic logic [GRADE_BITS-1:0] shaped_grade(grade_shape_t shape, int unsigned i,
                                                         int unsigned peak, int unsigned slope,
                                                         logic [GRADE_BITS-1:0] base);
    int unsigned gap, v;
    if ($urandom_range(11) == 0) return ($urandom_range(1) != 0) ? GRADE_TOP : '0;
    gap = (i > peak) ? i - peak : peak - i;
    case (shape)
      SHAPE_FLAT:    v = base;
      SHAPE_RISING:  v = base + i * slope;
      SHAPE_FALLING: v = (base > i * slope) ? base - i * slope : 0;
      SHAPE_PEAK:    v = (gap * slope >= GRADE_TOP) ? 0 : GRADE_TOP - gap * slope;
      default:       v = $urandom_range(GRADE_TOP);
    endcase
    return (v > GRADE_TOP) ? GRADE_TOP : v[GRADE_BITS-1:0];
  endfunction

  function automatic int unsigned queue_search();
    grade_shape_t shape;
    int unsigned n, peak, slope, i;
    logic [GRADE_BITS-1:0] base;
    shape = grade_shape_t'($urandom_range(SHAPE_PEAK));
    n = COARSE_STEPS + 1 + fine_points(stim_max);
    if ($urandom_range(7) == 0) begin
      n = $urandom_range(n - 1);
      searches_cut++;
    end
    peak = $urandom_range(n);
    slope = $urandom_range(3000, 1);
    base = GRADE_BITS'($urandom_range(GRADE_TOP));
    queue_item(ACT_START, GRADE_BITS'($urandom_range(GRADE_TOP)));
    for (i = 0; i < n; i++) queue_item(ACT_GRADE, shaped_grade(shape, i, peak, slope, base));
    searches++;
    return n + 1;
  endfunction

  function automatic logic [EXPOSURE_BITS-1:0] pick_setting();
    case ($urandom_range(2))
      0:       return NOTABLE_MAX[$urandom_range(9)];
      1:       return EXPOSURE_BITS'($urandom_range(2000));
      default: return EXPOSURE_BITS'($urandom_range(GRADE_TOP));
    endcase
  endfunction

  task automatic wait_for_drain();
    @(negedge clk);
    while (items_accepted != items_pushed || sweep_outputs_due.size() != 0) @(negedge clk);
  endtask

  task automatic load_max(logic [EXPOSURE_BITS-1:0] value);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    max_exposure_we <= 1'b1;
    max_exposure_data <= value;
    @(negedge clk);
    max_exposure_we <= 1'b0;
    @(posedge clk);
    stim_max = value;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned i, p, phase_items;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    queue_item(ACT_GRADE, GRADE_TOP);
    queue_item(ACT_START, GRADE_TOP);
    queue_item(ACT_GRADE, '0);
    queue_item(ACT_GRADE, '0);
    queue_item(ACT_GRADE, GRADE_TOP);
    queue_item(ACT_START, '0);

    load_max(16'd10);
    queue_item(ACT_START, 16'h5A5A);
    for (i = 0; i <= COARSE_STEPS; i++) queue_item(ACT_GRADE, (i == 5) ? 16'hF000 : 16'(i * 16));
    queue_item(ACT_GRADE, 16'hF000);
    queue_item(ACT_GRADE, GRADE_TOP);
    queue_item(ACT_GRADE, 16'h0001);

    for (p = 0; p < 3; p++) begin
      load_max((p == 0) ? 16'd9 : (p == 1) ? 16'hFFFF : 16'd0);
      send_idle_pct = (p == 0) ? 16 : (p == 1) ? 57 : 0;
      recv_idle_pct = (p == 0) ? 57 : (p == 1) ? 16 : 0;
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(3) == 0) load_max(pick_setting());
        phase_items += queue_search();
        if ($urandom_range(5) == 0)
          repeat ($urandom_range(3, 1))
            queue_item(ACT_GRADE, GRADE_BITS'($urandom_range(GRADE_TOP)));
      end
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d searches (%0d cut short) across %0d max_exposure settings",
             searches, searches_cut, settings_used);
    $display("%0d transactions accepted, %0d results checked, %0d bad",
             items_accepted, results_checked, bad_results);
    if (bad_results == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * 12);
    $display("Timeout after %0d cycles", RUN_LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end

endmodule
